@@ src/qpe_pkg.sv @@
// package for the query parameter extractor: types, constants and helpers
package qpe_pkg;

  // key storage
  localparam int unsigned MAX_KEY_BYTES = 8;
  localparam int unsigned KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
  localparam int unsigned KEY_W         = 8 * MAX_KEY_BYTES;

  // result queue
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_KEY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_VALUE  = 2'd1,
    PH_AFTER  = 2'd2
  } phase_e;

  typedef logic [MAX_KEY_BYTES-1:0][7:0] key_t;

  typedef struct packed {
    logic [7:0] query_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic       found;
  } out_t;

  typedef out_t [MAX_RESULTS-1:0] res_arr_t;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] compare_index;
    logic       segment_start;
    logic       segment_mismatch;
    logic [1:0] escape_count;
    logic [7:0] held_digit;
    logic       key_found;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:            PH_SEARCH,
    compare_index:    4'd0,
    segment_start:    1'b1,
    segment_mismatch: 1'b0,
    escape_count:     2'd0,
    held_digit:       8'd0,
    key_found:        1'b0
  };

  // hex digit value, anything else counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h41 + 8'd10;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h61 + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

@@ src/qpe_decoder.sv @@
// per-byte decision logic: next run state and the results one byte causes
module qpe_decoder (
  input  qpe_pkg::state_t   st_i,
  input  qpe_pkg::key_t     key_i,
  input  logic [3:0]        key_len_i,
  input  qpe_pkg::in_t      in_i,
  output qpe_pkg::state_t   st_o,
  output qpe_pkg::res_arr_t res_o,
  output logic [1:0]        res_cnt_o
);
  import qpe_pkg::*;

  state_t     nx;
  res_arr_t   res;
  logic [1:0] cnt;
  logic [3:0] len;
  logic [7:0] b;
  logic [7:0] kb;
  logic [7:0] held_out;

  // active key length, clipped to the key storage
  assign len = (key_len_i > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_len_i;
  assign b   = in_i.query_byte;
  assign kb  = key_i[st_i.compare_index[KEY_IDX_W-1:0]];

  always_comb begin
    nx       = st_i;
    res      = '0;
    cnt      = 2'd0;
    held_out = 8'd0;

    case (st_i.phase)
      // key matching within the current segment
      PH_SEARCH: begin
        if (!st_i.segment_start && b == CH_AMP) begin
          nx.segment_start    = 1'b1;
          nx.compare_index    = 4'd0;
          nx.segment_mismatch = 1'b0;
        end else begin
          nx.segment_start = 1'b0;
          if (!st_i.segment_mismatch) begin
            if (st_i.compare_index < len) begin
              if (b == kb) begin
                nx.compare_index = st_i.compare_index + 4'd1;
              end else begin
                nx.segment_mismatch = 1'b1;
              end
            end else if (b == CH_EQ) begin
              nx.key_found    = 1'b1;
              nx.phase        = PH_VALUE;
              nx.escape_count = 2'd0;
            end else begin
              nx.segment_mismatch = 1'b1;
            end
          end
        end
      end
      // value decoding
      PH_VALUE: begin
        if (b == CH_AMP) begin
          // flush a cut-short escape
          if (st_i.escape_count == 2'd1 || st_i.escape_count == 2'd2) begin
            res[cnt] = '{value_byte: CH_PERCENT, byte_valid: 1'b1,
                         done_res: 1'b0, found: 1'b0};
            cnt = cnt + 2'd1;
          end
          if (st_i.escape_count == 2'd2) begin
            held_out = (st_i.held_digit == CH_PLUS) ? CH_SPACE : st_i.held_digit;
            res[cnt] = '{value_byte: held_out, byte_valid: 1'b1,
                         done_res: 1'b0, found: 1'b0};
            cnt = cnt + 2'd1;
          end
          nx.escape_count = 2'd0;
          nx.phase        = PH_AFTER;
        end else if (st_i.escape_count == 2'd1) begin
          nx.held_digit   = b;
          nx.escape_count = 2'd2;
        end else if (st_i.escape_count == 2'd2) begin
          res[cnt] = '{value_byte: {hex_value(st_i.held_digit), hex_value(b)},
                       byte_valid: 1'b1, done_res: 1'b0, found: 1'b0};
          cnt = cnt + 2'd1;
          nx.escape_count = 2'd0;
        end else if (b == CH_PERCENT) begin
          nx.escape_count = 2'd1;
        end else if (b == CH_PLUS) begin
          res[cnt] = '{value_byte: CH_SPACE, byte_valid: 1'b1,
                       done_res: 1'b0, found: 1'b0};
          cnt = cnt + 2'd1;
        end else begin
          res[cnt] = '{value_byte: b, byte_valid: 1'b1,
                       done_res: 1'b0, found: 1'b0};
          cnt = cnt + 2'd1;
        end
      end
      // rest of the query is ignored
      PH_AFTER: begin
        nx = st_i;
      end
      default: begin
        nx = st_i;
      end
    endcase

    // end of query: flush any escape, report, restart the run
    if (in_i.last_byte) begin
      if (nx.phase == PH_VALUE) begin
        if (nx.escape_count == 2'd1 || nx.escape_count == 2'd2) begin
          res[cnt] = '{value_byte: CH_PERCENT, byte_valid: 1'b1,
                       done_res: 1'b0, found: 1'b0};
          cnt = cnt + 2'd1;
        end
        if (nx.escape_count == 2'd2) begin
          held_out = (nx.held_digit == CH_PLUS) ? CH_SPACE : nx.held_digit;
          res[cnt] = '{value_byte: held_out, byte_valid: 1'b1,
                       done_res: 1'b0, found: 1'b0};
          cnt = cnt + 2'd1;
        end
      end
      res[cnt] = '{value_byte: 8'd0, byte_valid: 1'b0,
                   done_res: 1'b1, found: nx.key_found};
      cnt = cnt + 2'd1;
      nx  = STATE_RESET;
    end
  end

  assign st_o      = nx;
  assign res_o     = res;
  assign res_cnt_o = cnt;

endmodule

@@ src/query_parameter_extractor.sv @@
// top level of the query parameter extractor: run state, configuration and result queue
// One query byte is taken per transaction and decided in the cycle it is accepted; a byte
// may cause up to three results (a flushed escape of two bytes plus the done result), which
// go into a four-entry result queue, are registered there and leave one per cycle while the
// output is not stalled. The input is stalled while the queue holds more than one result, so
// a stream of ordinary bytes runs at one byte per cycle while the output is not stalled. The
// search key and its length are written through the configuration port; the user must write
// them only while no query is in flight, the block itself does not enforce it.
module query_parameter_extractor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [qpe_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [qpe_pkg::KEY_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  qpe_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output qpe_pkg::out_t                      out_data_o
);
  import qpe_pkg::*;

  key_t             search_key_q;
  logic [3:0]       key_length_q;
  state_t           st_q, st_d;
  res_arr_t         res;
  logic [1:0]       res_cnt;
  out_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             in_acc;
  logic             out_pop;
  logic [1:0]       push_n;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_key_q <= '0;
      key_length_q <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEARCH_KEY: search_key_q <= cfg_data_i;
        REG_KEY_LENGTH: key_length_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // per-byte decision
  qpe_decoder u_decoder (
    .st_i      (st_q),
    .key_i     (search_key_q),
    .key_len_i (key_length_q),
    .in_i      (in_data_i),
    .st_o      (st_d),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  // handshakes
  assign in_stall_o  = (count_q > CNT_W'(1));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign out_pop     = out_valid_o && !out_stall_i;
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign push_n      = in_acc ? res_cnt : 2'd0;

  // run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  // queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_n);
    rd_ptr_d = out_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_n) - CNT_W'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue entries
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (in_acc && (2'(k) < res_cnt)) begin
        fifo_q[wr_ptr_q + PTR_W'(k)] <= res[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (count_q <= CNT_W'(1)))
    else $error("byte accepted without room for its results");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && !out_pop) |=> $stable(count_q))
    else $error("queue count moved without a transaction");

  a_run_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last_byte) |=>
      (st_q.phase == PH_SEARCH && st_q.segment_start && !st_q.key_found))
    else $error("run state not restarted after the last byte");
`endif

endmodule
